// ===== hw/rtl/vta_pkg.sv =====
// Package for the attitude angle pipeline: default parameters, CORDIC
// arctangent table and fixed-point constants. No dependencies.
`default_nettype none
package vta_pkg;

  localparam int SampleBitsDef    = 16;
  localparam int AngleFracBitsDef = 13;

  // Internal datapath widths
  localparam int DpW         = 64;  // CORDIC x/y and square-root working width
  localparam int AngW        = 36;  // Q30 angle accumulator, holds +-(pi + 1.75)
  localparam int CordicSteps = 31;
  localparam int SqrtSteps   = 32;

  localparam logic signed [AngW-1:0] PiQ30 = 36'sd3373259426;

  // atan(2^-i) in Q30 rad, rounded
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      default: v = (i < CordicSteps) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vector_to_attitude_angles.sv =====
// Attitude angles from one signed 3-vector: squares, two pipelined square
// roots and two pipelined CORDIC arctangent units. Uses vta_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  command | start_i, busy_o, mode_i, vec_x/y/z_i      | in
//  result  | valid_o, first_angle_o, second_angle_o,   | out
//          | degenerate_o                              |
//
// One item enters in every cycle; busy_o stays low. An item passes through the
// input register, square, sum, 32 square-root stages, a half-turn
// stage, 31 CORDIC stages and the output register. Each result shows for one
// cycle with valid_o. Reset clears only the valid bits; the pipeline never
// stalls since the receiver cannot hold results off.
`default_nettype none
module vector_to_attitude_angles import vta_pkg::*; #(
  parameter int SAMPLE_BITS     = SampleBitsDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              mode_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     vec_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     vec_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     vec_z_i,
  output logic                                   valid_o,
  output logic signed [ANGLE_FRAC_BITS+2:0]      first_angle_o,
  output logic signed [ANGLE_FRAC_BITS+1:0]      second_angle_o,
  output logic                                   degenerate_o
);

  localparam int SB       = SAMPLE_BITS;
  localparam int FW       = ANGLE_FRAC_BITS + 3;
  localparam int SW       = ANGLE_FRAC_BITS + 2;
  localparam int PreShift = (2 * SB < 61) ? (61 - 2 * SB) / 2 : 0;
  localparam int RndShift = 30 - ANGLE_FRAC_BITS;
  localparam int SqW      = 2 * SB;

  typedef struct packed {
    logic                 mode;
    logic                 deg;
    logic                 z_zero;
    logic                 z_neg;
    logic                 xy_zero;
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] y;
    logic signed [SB-1:0] z;
  } side_t;

  assign busy_o = 1'b0;

  // Input register
  logic                 v0_q;
  logic                 mode0_q;
  logic signed [SB-1:0] x0_q, y0_q, z0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode0_q <= mode_i;
      x0_q    <= vec_x_i;
      y0_q    <= vec_y_i;
      z0_q    <= vec_z_i;
    end
  end

  // Square magnitudes and classify the vector
  logic [SB-1:0]  mx, my, mz;
  logic           v1_q;
  logic [SqW-1:0] x2_q, y2_q, z2_q;
  side_t          s1_q, s1_d;

  always_comb begin
    mx = x0_q[SB-1] ? SB'(-x0_q) : SB'(x0_q);
    my = y0_q[SB-1] ? SB'(-y0_q) : SB'(y0_q);
    mz = z0_q[SB-1] ? SB'(-z0_q) : SB'(z0_q);
    s1_d.mode    = mode0_q;
    s1_d.z_zero  = (z0_q == '0);
    s1_d.z_neg   = z0_q[SB-1];
    s1_d.xy_zero = (x0_q == '0) && (y0_q == '0);
    s1_d.deg     = s1_d.xy_zero && s1_d.z_zero;
    s1_d.x       = x0_q;
    s1_d.y       = y0_q;
    s1_d.z       = z0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    x2_q <= mx * mx;
    y2_q <= my * my;
    z2_q <= mz * mz;
    s1_q <= s1_d;
  end

  // Form the two pre-scaled sums of squares (entry of the root stages)
  logic [DpW-1:0] sqn_a_q [SqrtSteps+1];
  logic [DpW-1:0] sqr_a_q [SqrtSteps+1];
  logic [DpW-1:0] sqn_b_q [SqrtSteps+1];
  logic [DpW-1:0] sqr_b_q [SqrtSteps+1];
  logic           sqv_q   [SqrtSteps+1];
  side_t          sqs_q   [SqrtSteps+1];
  logic [DpW-1:0] sum_a, sum_b;

  always_comb begin
    sum_a = s1_q.mode ? (DpW'(x2_q) + DpW'(y2_q)) : (DpW'(x2_q) + DpW'(z2_q));
    sum_b = DpW'(y2_q) + DpW'(z2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqv_q[0] <= 1'b0;
    else         sqv_q[0] <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    sqn_a_q[0] <= sum_a << (2 * PreShift);
    sqn_b_q[0] <= sum_b << (2 * PreShift);
    sqr_a_q[0] <= '0;
    sqr_b_q[0] <= '0;
    sqs_q[0]   <= s1_q;
  end

  // Restoring square root, one result bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [DpW-1:0] Bit = DpW'(1) << (62 - 2 * k);
    logic [DpW-1:0] rb_a, rb_b;

    assign rb_a = sqr_a_q[k] + Bit;
    assign rb_b = sqr_b_q[k] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sqv_q[k+1] <= 1'b0;
      else         sqv_q[k+1] <= sqv_q[k];
    end

    always_ff @(posedge clk_i) begin
      sqs_q[k+1] <= sqs_q[k];
      if (sqn_a_q[k] >= rb_a) begin
        sqn_a_q[k+1] <= sqn_a_q[k] - rb_a;
        sqr_a_q[k+1] <= (sqr_a_q[k] >> 1) + Bit;
      end else begin
        sqn_a_q[k+1] <= sqn_a_q[k];
        sqr_a_q[k+1] <= sqr_a_q[k] >> 1;
      end
      if (sqn_b_q[k] >= rb_b) begin
        sqn_b_q[k+1] <= sqn_b_q[k] - rb_b;
        sqr_b_q[k+1] <= (sqr_b_q[k] >> 1) + Bit;
      end else begin
        sqn_b_q[k+1] <= sqn_b_q[k];
        sqr_b_q[k+1] <= sqr_b_q[k] >> 1;
      end
    end
  end

  // Pick CORDIC operands and turn a negative x by a half turn
  logic signed [DpW-1:0] ax_q [CordicSteps+1];
  logic signed [DpW-1:0] ay_q [CordicSteps+1];
  logic signed [AngW-1:0] az_q [CordicSteps+1];
  logic signed [DpW-1:0] bx_q [CordicSteps+1];
  logic signed [DpW-1:0] by_q [CordicSteps+1];
  logic signed [AngW-1:0] bz_q [CordicSteps+1];
  logic                  cv_q [CordicSteps+1];
  side_t                 cs_q [CordicSteps+1];

  side_t                 ss;
  logic signed [DpW-1:0] scx, scy, scnz, ax0, ay0, bx0, by0;

  always_comb begin
    ss   = sqs_q[SqrtSteps];
    scx  = DpW'(ss.x) <<< PreShift;
    scy  = DpW'(ss.y) <<< PreShift;
    scnz = (-DpW'(ss.z)) <<< PreShift;
    ax0  = ss.mode ? scx : $signed(sqr_a_q[SqrtSteps]);
    ay0  = scy;
    bx0  = ss.mode ? $signed(sqr_a_q[SqrtSteps]) : $signed(sqr_b_q[SqrtSteps]);
    by0  = ss.mode ? scnz : scx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else         cv_q[0] <= sqv_q[SqrtSteps];
  end

  always_ff @(posedge clk_i) begin
    cs_q[0] <= ss;
    if (ax0[DpW-1]) begin
      ax_q[0] <= -ax0;
      ay_q[0] <= -ay0;
      az_q[0] <= ay0[DpW-1] ? -PiQ30 : PiQ30;
    end else begin
      ax_q[0] <= ax0;
      ay_q[0] <= ay0;
      az_q[0] <= '0;
    end
    if (bx0[DpW-1]) begin
      bx_q[0] <= -bx0;
      by_q[0] <= -by0;
      bz_q[0] <= by0[DpW-1] ? -PiQ30 : PiQ30;
    end else begin
      bx_q[0] <= bx0;
      by_q[0] <= by0;
      bz_q[0] <= '0;
    end
  end

  // CORDIC vectoring, one rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    localparam logic signed [AngW-1:0] Atan = AngW'(atan_q30(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else         cv_q[i+1] <= cv_q[i];
    end

    always_ff @(posedge clk_i) begin
      cs_q[i+1] <= cs_q[i];
      if (!ay_q[i][DpW-1]) begin
        ax_q[i+1] <= ax_q[i] + (ay_q[i] >>> i);
        ay_q[i+1] <= ay_q[i] - (ax_q[i] >>> i);
        az_q[i+1] <= az_q[i] + Atan;
      end else begin
        ax_q[i+1] <= ax_q[i] - (ay_q[i] >>> i);
        ay_q[i+1] <= ay_q[i] + (ax_q[i] >>> i);
        az_q[i+1] <= az_q[i] - Atan;
      end
      if (!by_q[i][DpW-1]) begin
        bx_q[i+1] <= bx_q[i] + (by_q[i] >>> i);
        by_q[i+1] <= by_q[i] - (bx_q[i] >>> i);
        bz_q[i+1] <= bz_q[i] + Atan;
      end else begin
        bx_q[i+1] <= bx_q[i] - (by_q[i] >>> i);
        by_q[i+1] <= by_q[i] + (bx_q[i] >>> i);
        bz_q[i+1] <= bz_q[i] - Atan;
      end
    end
  end

  // Round to output units and apply the sign and special cases
  side_t                  fs;
  logic signed [AngW-1:0] ra_w, rb_w;
  logic signed [FW-1:0]   ra;
  logic signed [SW-1:0]   rb;
  logic signed [FW-1:0]   first_d;
  logic signed [SW-1:0]   second_d;

  always_comb begin
    fs   = cs_q[CordicSteps];
    ra_w = (az_q[CordicSteps] + (AngW'(1) <<< (RndShift - 1))) >>> RndShift;
    rb_w = (bz_q[CordicSteps] + (AngW'(1) <<< (RndShift - 1))) >>> RndShift;
    ra   = ra_w[FW-1:0];
    rb   = rb_w[SW-1:0];
    first_d  = '0;
    second_d = '0;
    if (fs.deg) begin
      first_d  = '0;
      second_d = '0;
    end else if (!fs.mode) begin
      if (!fs.z_zero) begin
        first_d  = fs.z_neg ? -ra : ra;
        second_d = fs.z_neg ? rb : -rb;
      end
    end else begin
      first_d  = fs.xy_zero ? '0 : ra;
      second_d = rb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= cv_q[CordicSteps];
  end

  always_ff @(posedge clk_i) begin
    first_angle_o  <= first_d;
    second_angle_o <= second_d;
    degenerate_o   <= fs.deg;
  end

endmodule
`default_nettype wire

// ===== dv/vector_to_attitude_angles_tb.sv =====
// Testbench for vector_to_attitude_angles: directed and random vectors in both
// modes, checked item by item against a CORDIC predictor. Depends on vta_pkg.
`default_nettype none
module vector_to_attitude_angles_tb;
  import vta_pkg::*;

  localparam int SW = SampleBitsDef;
  localparam int FW = AngleFracBitsDef;
  localparam int PreShift = (2 * SW < 61) ? (61 - 2 * SW) / 2 : 0;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 100;

  typedef struct packed {
    logic [FW+2:0] first;
    logic [FW+1:0] second;
    logic          degen;
  } angles_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 mode_i = 1'b0;
  logic signed [SW-1:0] vec_x_i = '0;
  logic signed [SW-1:0] vec_y_i = '0;
  logic signed [SW-1:0] vec_z_i = '0;
  logic                 valid_o;
  logic signed [FW+2:0] first_angle_o;
  logic signed [FW+1:0] second_angle_o;
  logic                 degenerate_o;

  angles_t angles_q[$];
  int      errors = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;

  vector_to_attitude_angles dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .vec_x_i, .vec_y_i, .vec_z_i,
    .valid_o, .first_angle_o, .second_angle_o, .degenerate_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Floor square root, bit by bit
  function automatic longint floor_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint mag_of(longint a, longint b);
    logic [63:0] s;
    s = 64'(a * a + b * b);
    return floor_sqrt(s << (2 * PreShift));
  endfunction

  // Vectoring CORDIC arctangent of (num / den), Q30 rad
  function automatic longint arctan_q30(longint den, longint num);
    longint ang, dx, dy;
    ang = 0;
    if (den < 0) begin
      ang = (num >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
      den = -den;
      num = -num;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = num >>> i;
      dy = den >>> i;
      if (num >= 0) begin
        den = den + dx;
        num = num - dy;
        ang = ang + longint'(atan_q30(i));
      end else begin
        den = den - dx;
        num = num + dy;
        ang = ang - longint'(atan_q30(i));
      end
    end
    return ang;
  endfunction

  function automatic longint round_angle(longint q30);
    return (q30 + (longint'(1) << (29 - FW))) >>> (30 - FW);
  endfunction

  function automatic angles_t predict_angles(logic mode, longint x, longint y, longint z);
    angles_t res;
    longint  a1, a2, rl, pt;
    a1 = 0;
    a2 = 0;
    res.degen = 1'b0;
    if (x == 0 && y == 0 && z == 0) begin
      res.degen = 1'b1;
    end else if (mode == 1'b0) begin
      if (z != 0) begin
        rl = round_angle(arctan_q30(mag_of(x, z), y <<< PreShift));
        pt = round_angle(arctan_q30(mag_of(y, z), x <<< PreShift));
        a1 = (z > 0) ? rl : -rl;
        a2 = (z > 0) ? -pt : pt;
      end
    end else begin
      if (x != 0 || y != 0) a1 = round_angle(arctan_q30(x <<< PreShift, y <<< PreShift));
      a2 = round_angle(arctan_q30(mag_of(x, y), (-z) <<< PreShift));
    end
    res.first = a1[FW+2:0];
    res.second = a2[FW+1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", field, got, want, results_seen);
  endtask

  // Compare each result with the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (angles_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        angles_t want;
        want = angles_q.pop_front();
        if (first_angle_o !== want.first)
          report_mismatch("first_angle", first_angle_o, $signed(want.first));
        if (second_angle_o !== want.second)
          report_mismatch("second_angle", second_angle_o, $signed(want.second));
        if (degenerate_o !== want.degen)
          report_mismatch("degenerate", degenerate_o, want.degen);
      end
      results_seen++;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drive one item after a random gap; entered and left just after a falling edge
  task automatic send_item(logic mode, logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                           logic signed [SW-1:0] z);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= mode;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    angles_q.push_back(predict_angles(mode, x, y, z));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic test_degenerate();
    send_item(1'b0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0);
  endtask

  // Mode 0 with z zero, mode 1 with no horizontal part or with a negative x
  task automatic test_special_axes();
    send_item(1'b0, 100, -200, 0);
    send_item(1'b0, -32768, 32767, 0);
    send_item(1'b1, 0, 0, 1);
    send_item(1'b1, 0, 0, -1);
    send_item(1'b1, 0, 0, 32767);
    send_item(1'b1, 0, 0, -32768);
    send_item(1'b1, -5, 0, 7);
    send_item(1'b1, -5, -1, 7);
  endtask

  task automatic test_extremes();
    logic signed [SW-1:0] ext[4] = '{-32768, -1, 1, 32767};
    for (int k = 0; k < 12; k++)
      send_item(k[0], ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
                ext[$urandom_range(0, 3)]);
  endtask

  // Mix of full-range, small, sparse and degenerate vectors
  task automatic test_random(int count);
    logic signed [SW-1:0] v[3];
    for (int n = 0; n < count; n++) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 9))
          0:       v[c] = 0;
          1, 2:    v[c] = SW'(int'($urandom_range(0, 64)) - 32);
          3:       v[c] = ($urandom_range(0, 1)) ? 32767 : -32768;
          default: v[c] = SW'($urandom);
        endcase
      end
      if ($urandom_range(0, 49) == 0) v = '{0, 0, 0};
      send_item(1'($urandom), v[0], v[1], v[2]);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_degenerate();
    test_special_axes();
    test_extremes();
    test_random(1300);
    start_i <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d vectors in both modes, %0d results checked", items_sent, results_seen);
    $display("covered zero vectors, axis cases, extremes and random gaps");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
